// ----- design/brr_pkg.sv -----
// Shared types, constants and the exponent factor table of the baroreceptor reflex block.
`timescale 1ns / 1ps
package brr_pkg;

  localparam logic [12:0] FracOne = 13'd4096;
  localparam logic [12:0] FracHalf = 13'd2048;
  localparam logic [30:0] ExpOne = 31'd1073741824;
  localparam logic signed [15:0] LevelReset = 16'sd4096;

  localparam logic [2:0] RegSlope = 3'd0;
  localparam logic [2:0] RegRate = 3'd1;
  localparam logic [2:0] RegElast = 3'd2;
  localparam logic [2:0] RegResist = 3'd3;
  localparam logic [2:0] RegCompl = 3'd4;

  typedef struct packed {
    logic        active;
    logic [15:0] pressure;
    logic [15:0] set_point;
  } brr_item_t;

  typedef struct packed {
    logic [15:0] slope;
    logic [63:0] rate;
    logic [47:0] elast;
    logic [47:0] resist;
    logic [47:0] compl;
  } brr_cfg_t;

  // Factor 2^(-2^-k) in Q.30 for fraction bit k of the exponent.
  function automatic logic [30:0] exp_factor(input logic [4:0] k);
    logic [30:0] f;
    case (k)
      5'd1: f = 31'd759250125;
      5'd2: f = 31'd902905651;
      5'd3: f = 31'd984625594;
      5'd4: f = 31'd1028218693;
      5'd5: f = 31'd1050733751;
      5'd6: f = 31'd1062175491;
      5'd7: f = 31'd1067942999;
      5'd8: f = 31'd1070838486;
      5'd9: f = 31'd1072289173;
      5'd10: f = 31'd1073015252;
      5'd11: f = 31'd1073378477;
      5'd12: f = 31'd1073560135;
      default: f = ExpOne;
    endcase
    return f;
  endfunction

endpackage

// ----- design/baroreceptor_reflex_step_top.sv -----
// Top level of the baroreceptor reflex step: configuration registers, front end and back end.
//
//   channel  direction  handshake                 word
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   feedback flag, pressures, deltas, drug flag
//   out      out        out_valid_o / out_stall_i four Q4.12 scales
//
// An active word passes through the bit-serial log2 squaring, the exp2 factor products and the
// 13-step divider in the back end.
// A word with zero pressure skips to the lag updates; an inactive word goes straight to output.
// Reset puts all four levels at 1.0 and the slope at 1.0; coefficients clear to zero.
// The front queue holds two words; in_stall_o rises only when it is full.
// A finished word waits in the output register while the back end starts the next one.
`timescale 1ns / 1ps
module baroreceptor_reflex_step_top import brr_pkg::*; #(
  parameter int LogTableBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               feedback_active_i,
  input  logic [15:0]        arterial_pressure_i,
  input  logic [15:0]        baseline_set_point_i,
  input  logic signed [15:0] exercise_delta_i,
  input  logic signed [15:0] drug_delta_i,
  input  logic               drug_applies_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] rate_scale_o,
  output logic signed [15:0] elastance_scale_o,
  output logic signed [15:0] resistance_scale_o,
  output logic signed [15:0] compliance_scale_o
);

  brr_cfg_t  cfg_q;
  brr_item_t head;
  logic      head_valid;
  logic      pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope <= 16'd4096;
      cfg_q.rate <= '0;
      cfg_q.elast <= '0;
      cfg_q.resist <= '0;
      cfg_q.compl <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSlope: cfg_q.slope <= cfg_data_i[15:0];
        RegRate: cfg_q.rate <= cfg_data_i;
        RegElast: cfg_q.elast <= cfg_data_i[47:0];
        RegResist: cfg_q.resist <= cfg_data_i[47:0];
        RegCompl: cfg_q.compl <= cfg_data_i[47:0];
        default: begin
        end
      endcase
    end
  end

  brr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .feedback_active_i,
    .arterial_pressure_i,
    .baseline_set_point_i,
    .exercise_delta_i,
    .drug_delta_i,
    .drug_applies_i,
    .head_valid_o(head_valid),
    .head_o(head),
    .pop_i(pop)
  );

  brr_back #(.LogTableBits(LogTableBits)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i(cfg_q),
    .head_valid_i(head_valid),
    .head_i(head),
    .pop_o(pop),
    .out_valid_o,
    .out_stall_i,
    .rate_scale_o,
    .elastance_scale_o,
    .resistance_scale_o,
    .compliance_scale_o
  );

endmodule

// ----- design/brr_front.sv -----
// Front end: takes input words, forms the saturated set point and queues the work.
`timescale 1ns / 1ps
module brr_front import brr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              feedback_active_i,
  input  logic [15:0]       arterial_pressure_i,
  input  logic [15:0]       baseline_set_point_i,
  input  logic signed [15:0] exercise_delta_i,
  input  logic signed [15:0] drug_delta_i,
  input  logic              drug_applies_i,
  output logic              head_valid_o,
  output brr_item_t         head_o,
  input  logic              pop_i
);

  brr_item_t      entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic signed [18:0] sum;
  logic [15:0]    sp;
  logic           push;

  always_comb begin
    sum = $signed({3'b000, baseline_set_point_i}) + 19'(exercise_delta_i);
    if (drug_applies_i) begin
      sum = sum + 19'(drug_delta_i);
    end
    if (sum < 19'sd1) begin
      sp = 16'd1;
    end else if (sum > 19'sd65535) begin
      sp = 16'hFFFF;
    end else begin
      sp = sum[15:0];
    end
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{active: feedback_active_i, pressure: arterial_pressure_i,
                             set_point: sp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count exceeds depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

endmodule

// ----- design/brr_back.sv -----
// Back end: log2 and exp2 power, sigmoid divide and the four lag updates.
`timescale 1ns / 1ps
module brr_back import brr_pkg::*; #(
  parameter int LogTableBits = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brr_cfg_t          cfg_i,
  input  logic              head_valid_i,
  input  brr_item_t         head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [15:0] rate_scale_o,
  output logic signed [15:0] elastance_scale_o,
  output logic signed [15:0] resistance_scale_o,
  output logic signed [15:0] compliance_scale_o
);

  localparam int LrW = LogTableBits + 6;
  localparam int TW = LrW + 17;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOG = 4'd1;
  localparam logic [3:0] S_MUL = 4'd2;
  localparam logic [3:0] S_ABS = 4'd3;
  localparam logic [3:0] S_EXP = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_FRAC = 4'd7;
  localparam logic [3:0] S_LAG = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] ym_q, ym_d, ys_q, ys_d;
  logic [3:0]  mm_q, mm_d, ms_q, ms_d;
  logic [LogTableBits-1:0] fm_q, fm_d, fs_q, fs_d, fb_q, fb_d;
  logic signed [TW-1:0] t_q, t_d;
  logic [TW-1:0] a_q, a_d;
  logic [30:0] p_q, p_d;
  logic [43:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [12:0] quo_q, quo_d;
  logic [12:0] sym_q, sym_d, para_q, para_d;
  logic signed [15:0] lvl_q [4];
  logic signed [15:0] lvl_d [4];
  logic signed [29:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [31:0] inner_q, inner_d;
  logic signed [47:0] pg_q, pg_d;
  logic out_valid_q, out_valid_d;
  logic signed [15:0] out_q [4];
  logic out_load;

  logic [3:0]  m_map, m_sp;
  logic [31:0] sq_m, sq_s;
  logic signed [LrW-1:0] lr;
  logic [TW-1:0] ai_full;
  logic [61:0] eprod;
  logic [43:0] dsub;
  logic [1:0]  ch;
  logic [1:0]  ph;
  logic signed [15:0] gain, alpha, beta, gamma, lvl_sel;
  logic [12:0] wsel;
  logic signed [47:0] rnd;
  logic signed [25:0] sum_lvl;

  always_comb begin
    m_map = 4'd0;
    m_sp = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (head_i.pressure[i]) m_map = 4'(i);
      if (head_i.set_point[i]) m_sp = 4'(i);
    end
  end

  assign ch = cnt_q[3:2];
  assign ph = cnt_q[1:0];

  always_comb begin
    lvl_sel = lvl_q[ch];
    gain = cfg_i.elast[15:0];
    alpha = cfg_i.elast[31:16];
    beta = '0;
    gamma = cfg_i.elast[47:32];
    wsel = sym_q;
    case (ch)
      2'd0: begin
        gain = cfg_i.rate[15:0];
        alpha = cfg_i.rate[31:16];
        beta = cfg_i.rate[47:32];
        gamma = cfg_i.rate[63:48];
      end
      2'd1: begin
        gain = cfg_i.elast[15:0];
        alpha = cfg_i.elast[31:16];
        gamma = cfg_i.elast[47:32];
      end
      2'd2: begin
        gain = cfg_i.resist[15:0];
        alpha = cfg_i.resist[31:16];
        gamma = cfg_i.resist[47:32];
      end
      default: begin
        gain = cfg_i.compl[15:0];
        alpha = cfg_i.compl[31:16];
        gamma = cfg_i.compl[47:32];
        wsel = para_q;
      end
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ym_d = ym_q;
    ys_d = ys_q;
    mm_d = mm_q;
    ms_d = ms_q;
    fm_d = fm_q;
    fs_d = fs_q;
    fb_d = fb_q;
    t_d = t_q;
    a_d = a_q;
    p_d = p_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    sym_d = sym_q;
    para_d = para_q;
    p1_d = p1_q;
    p2_d = p2_q;
    inner_d = inner_q;
    pg_d = pg_q;
    lvl_d = lvl_q;
    pop_o = 1'b0;
    sq_m = ym_q * ym_q;
    sq_s = ys_q * ys_q;
    lr = (LrW'($signed({1'b0, mm_q})) - LrW'($signed({1'b0, ms_q}))) <<< LogTableBits;
    lr = lr + LrW'($signed({1'b0, fm_q})) - LrW'($signed({1'b0, fs_q}));
    ai_full = a_q >> (12 + LogTableBits);
    eprod = p_q * exp_factor(cnt_q);
    dsub = 44'(den_q) << cnt_q[3:0];
    rnd = (pg_q + 48'sd8388608) >>> 24;
    sum_lvl = 26'(lvl_sel) + 26'(rnd);
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          if (!head_i.active) begin
            state_d = S_DONE;
          end else if (head_i.pressure == 16'd0) begin
            sym_d = (cfg_i.slope == 16'd0) ? FracHalf : FracOne;
            para_d = (cfg_i.slope == 16'd0) ? FracHalf : 13'd0;
            cnt_d = '0;
            state_d = S_LAG;
          end else begin
            mm_d = m_map;
            ms_d = m_sp;
            ym_d = 16'(head_i.pressure << (4'd15 - m_map));
            ys_d = 16'(head_i.set_point << (4'd15 - m_sp));
            fm_d = '0;
            fs_d = '0;
            cnt_d = '0;
            state_d = S_LOG;
          end
        end
      end
      S_LOG: begin
        fm_d = {fm_q[LogTableBits-2:0], sq_m[31]};
        fs_d = {fs_q[LogTableBits-2:0], sq_s[31]};
        ym_d = sq_m[31] ? sq_m[31:16] : sq_m[30:15];
        ys_d = sq_s[31] ? sq_s[31:16] : sq_s[30:15];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(LogTableBits - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        t_d = TW'($signed({1'b0, cfg_i.slope})) * TW'(lr);
        state_d = S_ABS;
      end
      S_ABS: begin
        a_d = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
        state_d = S_EXP;
        cnt_d = 5'd1;
        p_d = ExpOne;
      end
      S_EXP: begin
        if (cnt_q == 5'd1) begin
          fb_d = a_q[12 +: LogTableBits];
        end else begin
          fb_d = {fb_q[LogTableBits-2:0], 1'b0};
        end
        if ((cnt_q == 5'd1) ? a_q[12 + LogTableBits - 1] : fb_q[LogTableBits-2]) begin
          p_d = eprod[60:30];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(LogTableBits)) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (ai_full >= TW'(31)) begin
          p_d = '0;
        end else begin
          p_d = p_q >> ai_full[4:0];
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_init_q) begin
          den_d = 32'(ExpOne) + 32'(p_q);
          rem_d = (44'(p_q) << 12) + 44'(den_d >> 1);
          quo_d = '0;
          cnt_d = 5'd12;
        end
      end
      S_FRAC: begin
        sym_d = t_q[TW-1] ? FracOne - quo_q : quo_q;
        para_d = t_q[TW-1] ? quo_q : FracOne - quo_q;
        cnt_d = '0;
        state_d = S_LAG;
      end
      S_LAG: begin
        case (ph)
          2'd0: begin
            p1_d = 30'(alpha) * 30'($signed({1'b0, wsel}));
            p2_d = (ch == 2'd0) ? 30'(beta) * 30'($signed({1'b0, para_q})) : '0;
          end
          2'd1: begin
            inner_d = ((32'(gamma) - 32'(lvl_sel)) <<< 12) + 32'(p1_q) - 32'(p2_q);
          end
          2'd2: begin
            pg_d = 48'(gain) * 48'(inner_q);
          end
          default: begin
            if (sum_lvl > 26'sd32767) begin
              lvl_d[ch] = 16'sh7FFF;
            end else if (sum_lvl < -26'sd32768) begin
              lvl_d[ch] = -16'sd32768;
            end else begin
              lvl_d[ch] = sum_lvl[15:0];
            end
          end
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_q == S_SHIFT) begin
      cnt_d = 5'd0;
    end
  end

  // Division runs in two phases: the entry cycle loads the operands, then one
  // quotient bit per cycle from bit 12 down to bit 0.
  logic div_init_q;
  logic div_init_d;
  logic [43:0] div_rem_n;
  logic [12:0] div_quo_n;
  logic [4:0]  div_cnt_n;
  logic [3:0]  div_state_n;

  always_comb begin
    div_init_d = div_init_q;
    div_rem_n = rem_d;
    div_quo_n = quo_d;
    div_cnt_n = cnt_d;
    div_state_n = state_d;
    if (state_q == S_SHIFT) begin
      div_init_d = 1'b1;
    end else if (state_q == S_DIV && div_init_q) begin
      div_init_d = 1'b0;
    end else if (state_q == S_DIV) begin
      if (rem_q >= dsub) begin
        div_rem_n = rem_q - dsub;
        div_quo_n = quo_q | (13'd1 << cnt_q[3:0]);
      end else begin
        div_rem_n = rem_q;
        div_quo_n = quo_q;
      end
      div_cnt_n = cnt_q - 5'd1;
      div_state_n = (cnt_q == 5'd0) ? S_FRAC : S_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    ym_q <= ym_d;
    ys_q <= ys_d;
    mm_q <= mm_d;
    ms_q <= ms_d;
    fm_q <= fm_d;
    fs_q <= fs_d;
    fb_q <= fb_d;
    t_q <= t_d;
    a_q <= a_d;
    p_q <= p_d;
    rem_q <= div_rem_n;
    den_q <= den_d;
    quo_q <= div_quo_n;
    sym_q <= sym_d;
    para_q <= para_d;
    p1_q <= p1_d;
    p2_q <= p2_d;
    inner_q <= inner_d;
    pg_q <= pg_d;
    if (out_load) begin
      out_q <= lvl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      div_init_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lvl_q[i] <= LevelReset;
      end
    end else begin
      state_q <= div_state_n;
      cnt_q <= div_cnt_n;
      div_init_q <= div_init_d;
      out_valid_q <= out_valid_d;
      lvl_q <= lvl_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_scale_o = out_q[0];
  assign elastance_scale_o = out_q[1];
  assign resistance_scale_o = out_q[2];
  assign compliance_scale_o = out_q[3];

  a_frac_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LAG |-> ({1'b0, sym_q} + {1'b0, para_q}) == {1'b0, FracOne})
    else $error("fractions do not sum to one");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FRAC |-> quo_q <= FracHalf)
    else $error("sigmoid quotient above one half");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result not presented after completion");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE && head_valid_i)
    else $error("queue popped outside idle");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the baroreceptor reflex step: directed table, then random ticks.
`timescale 1ns / 1ps
module tb_top;
  import brr_pkg::*;

  typedef struct {
    logic        active;
    logic [15:0] pressure;
    logic [15:0] baseline;
    logic [15:0] exercise;
    logic [15:0] drug;
    logic        drug_on;
    logic        has_expect;
    logic [15:0] exp_rate;
  } tick_t;

  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] elast;
    logic [15:0] resist;
    logic [15:0] compl;
  } scales_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = RegSlope;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic active = 1'b0;
  logic [15:0] pressure = '0;
  logic [15:0] baseline = 16'd1;
  logic signed [15:0] exercise = '0;
  logic signed [15:0] drug = '0;
  logic drug_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] rate_o, elast_o, resist_o, compl_o;

  logic [15:0] m_slope;
  logic [63:0] m_rate;
  logic [47:0] m_elast, m_resist, m_compl;
  logic signed [15:0] lv_rate, lv_elast, lv_resist, lv_compl;

  scales_t expected_scales[$];
  logic [15:0] typed_rate[$];
  logic typed_valid[$];
  int errors = 0;
  int checked = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold_on = 1'b0;
  event hold_start;

  baroreceptor_reflex_step_top u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .feedback_active_i(active), .arterial_pressure_i(pressure),
    .baseline_set_point_i(baseline), .exercise_delta_i(exercise),
    .drug_delta_i(drug), .drug_applies_i(drug_on), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .rate_scale_o(rate_o), .elastance_scale_o(elast_o),
    .resistance_scale_o(resist_o), .compliance_scale_o(compl_o)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Timeout after %0d checked words", checked);
    $display("FAILURE");
    $finish;
  end

  function automatic longint signed fld(input logic [63:0] w, input int pos);
    return longint'($signed(w[pos +: 16]));
  endfunction

  function automatic longint signed log2_fix(input longint unsigned x);
    int msb;
    longint unsigned y;
    longint signed fr;
    msb = 15;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    y = x << (15 - msb);
    fr = 0;
    for (int k = 0; k < 8; k++) begin
      y = (y * y) >> 15;
      fr = fr * 2;
      if (y >= 65536) begin
        fr = fr + 1;
        y = y >> 1;
      end
    end
    return longint'(msb - 8) * 256 + fr;
  endfunction

  function automatic longint signed round_q24(input longint signed v);
    longint signed w;
    w = v + (64'sd1 <<< 23);
    return w >>> 24;
  endfunction

  function automatic logic signed [15:0] lag_step(input logic signed [15:0] lv,
      input longint signed gain, input longint signed inner);
    longint signed v;
    v = longint'(lv) + round_q24(gain * inner);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic scales_t advance_levels(input logic act, input logic [15:0] map,
      input logic [15:0] base, input logic [15:0] ex, input logic [15:0] dr, input logic don);
    longint signed sp, sym, para, lr, t, q;
    longint unsigned a, ai, fb, p, den;
    scales_t r;
    if (act) begin
      sp = longint'(base) + longint'($signed(ex));
      if (don) sp += longint'($signed(dr));
      if (sp < 1) sp = 1;
      if (sp > 65535) sp = 65535;
      if (map == 0) begin
        sym = (m_slope == 0) ? 2048 : 4096;
      end else begin
        lr = log2_fix(map) - log2_fix(sp);
        t = longint'(m_slope) * lr;
        a = (t < 0) ? -t : t;
        ai = a >> 20;
        fb = (a >> 12) & 255;
        p = 1073741824;
        for (int k = 1; k <= 8; k++)
          if (fb[8 - k]) p = (p * longint'(exp_factor(k[4:0]))) >> 30;
        p = (ai >= 31) ? 0 : (p >> ai);
        den = 1073741824 + p;
        q = ((p << 12) + (den >> 1)) / den;
        sym = (t >= 0) ? q : 4096 - q;
      end
      para = 4096 - sym;
      lv_rate = lag_step(lv_rate, fld(m_rate, 0), (fld(m_rate, 48) - lv_rate) * 4096
          + fld(m_rate, 16) * sym - fld(m_rate, 32) * para);
      lv_elast = lag_step(lv_elast, fld(m_elast, 0),
          (fld(m_elast, 32) - lv_elast) * 4096 + fld(m_elast, 16) * sym);
      lv_resist = lag_step(lv_resist, fld(m_resist, 0),
          (fld(m_resist, 32) - lv_resist) * 4096 + fld(m_resist, 16) * sym);
      lv_compl = lag_step(lv_compl, fld(m_compl, 0),
          (fld(m_compl, 32) - lv_compl) * 4096 + fld(m_compl, 16) * para);
    end
    r.rate = lv_rate;
    r.elast = lv_elast;
    r.resist = lv_resist;
    r.compl = lv_compl;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegSlope: m_slope = val[15:0];
      RegRate: m_rate = val;
      RegElast: m_elast = val[47:0];
      RegResist: m_resist = val[47:0];
      RegCompl: m_compl = val[47:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input tick_t tk);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    active <= tk.active;
    pressure <= tk.pressure;
    baseline <= tk.baseline;
    exercise <= tk.exercise;
    drug <= tk.drug;
    drug_on <= tk.drug_on;
    expected_scales.push_back(advance_levels(tk.active, tk.pressure, tk.baseline,
        tk.exercise, tk.drug, tk.drug_on));
    typed_valid.push_back(tk.has_expect);
    typed_rate.push_back(tk.exp_rate);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_scales.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic tick_t mk(input logic act, input logic [15:0] map, input logic [15:0] b,
      input logic [15:0] ex, input logic [15:0] dr, input logic don,
      input logic he, input logic [15:0] er);
    tick_t t;
    t = '{act, map, b, ex, dr, don, he, er};
    return t;
  endfunction

  function automatic logic [63:0] rand_coef(input int mode);
    logic [63:0] w;
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0: w[i*16 +: 16] = 16'($urandom_range(8191, 0)) - 16'd4096;
        1: w[i*16 +: 16] = (i == 0) ? 16'h7fff : 16'h8000;
        default: w[i*16 +: 16] = 16'($urandom());
      endcase
    end
    return w;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.active = ($urandom_range(9, 0) != 0);
    t.pressure = ($urandom_range(19, 0) == 0) ? 16'd0 :
        ($urandom_range(3, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(40000, 12000));
    t.baseline = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 1)) :
        16'($urandom_range(30000, 20000));
    t.exercise = ($urandom_range(3, 0) == 0) ? 16'($urandom()) :
        16'($signed(16'($urandom_range(4000, 0))) - 16'sd2000);
    t.drug = ($urandom_range(3, 0) == 0) ? 16'($urandom()) :
        16'($signed(16'($urandom_range(4000, 0))) - 16'sd2000);
    t.drug_on = 1'($urandom_range(1, 0));
    t.has_expect = 1'b0;
    t.exp_rate = '0;
    return t;
  endfunction

  // A long receiver hold, counted in its own process.
  always begin
    @(hold_start);
    hold_on = 1'b1;
    repeat (400) @(posedge clk);
    hold_on = 1'b0;
  end

  // Output side: stall control and comparison against the oldest prediction.
  always @(posedge clk) begin
    scales_t e;
    logic te;
    logic [15:0] tr;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_scales.size() == 0) begin
          $display("%0t: unexpected word rate=%h", $time, rate_o);
          errors++;
        end else begin
          e = expected_scales.pop_front();
          te = typed_valid.pop_front();
          tr = typed_rate.pop_front();
          checked++;
          if (te && tr != rate_o) begin
            $display("%0t: rate table exp %h act %h", $time, tr, rate_o);
            errors++;
          end
          if (e.rate != rate_o) begin
            $display("%0t: rate exp %h act %h", $time, e.rate, rate_o); errors++;
          end
          if (e.elast != elast_o) begin
            $display("%0t: elast exp %h act %h", $time, e.elast, elast_o); errors++;
          end
          if (e.resist != resist_o) begin
            $display("%0t: resist exp %h act %h", $time, e.resist, resist_o); errors++;
          end
          if (e.compl != compl_o) begin
            $display("%0t: compl exp %h act %h", $time, e.compl, compl_o); errors++;
          end
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_idle > 0) && ($urandom_range(99, 0) < recv_idle);
      end
    end
  end

  initial begin
    tick_t dir[$];
    int phase;
    m_slope = 16'd4096;
    m_rate = '0; m_elast = '0; m_resist = '0; m_compl = '0;
    lv_rate = LevelReset; lv_elast = LevelReset; lv_resist = LevelReset;
    lv_compl = LevelReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With reset coefficients every level stays at 1.0.
    dir.push_back(mk(1, 16'd25600, 16'd25600, 0, 0, 0, 1, 16'd4096));
    dir.push_back(mk(0, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 1, 1, 16'd4096));
    foreach (dir[i]) send_tick(dir[i]);
    drain();

    write_reg(RegRate, 64'h0000_0800_0800_1000);
    write_reg(RegElast, 64'h1000_0800_0400);
    write_reg(RegResist, 64'h1000_f800_0400);
    write_reg(RegCompl, 64'h1000_0800_0400);
    write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
    dir.delete();
    dir.push_back(mk(1, 16'd0, 16'd25600, 0, 0, 0, 0, 0));
    dir.push_back(mk(1, 16'hffff, 16'd1, 0, 0, 0, 0, 0));
    dir.push_back(mk(1, 16'd1, 16'hffff, 0, 0, 0, 0, 0));
    dir.push_back(mk(1, 16'd25600, 16'd100, 16'h8000, 0, 0, 0, 0));
    dir.push_back(mk(1, 16'd25600, 16'hffff, 16'h7fff, 16'h7fff, 1, 0, 0));
    dir.push_back(mk(1, 16'd25600, 16'd25600, 0, 16'h8000, 1, 0, 0));
    dir.push_back(mk(1, 16'd25600, 16'd25600, 0, 16'h8000, 0, 0, 0));
    dir.push_back(mk(0, 16'd30000, 16'd25600, 0, 0, 0, 0, 0));
    dir.push_back(mk(1, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 1, 0, 0));
    foreach (dir[i]) send_tick(dir[i]);
    drain();
    write_reg(RegSlope, 64'd0);
    send_tick(mk(1, 16'd0, 16'd25600, 0, 0, 0, 0, 0));
    send_tick(mk(1, 16'd30000, 16'd25600, 0, 0, 0, 0, 0));
    drain();
    write_reg(RegSlope, 64'hffff);
    send_tick(mk(1, 16'd30000, 16'd25600, 0, 0, 0, 0, 0));
    send_tick(mk(1, 16'd20000, 16'd25600, 0, 0, 0, 0, 0));
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 71; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 71; end
        default: begin send_idle = 7; recv_idle = 7; end
      endcase
      write_reg(RegSlope, 64'((phase == 4) ? 16'hffff : (phase == 5) ? 16'd0 :
          16'($urandom_range(24000, 0))));
      write_reg(RegRate, rand_coef(phase == 6 ? 1 : phase == 7 ? 2 : 0));
      write_reg(RegElast, rand_coef(phase == 6 ? 1 : phase == 7 ? 2 : 0));
      write_reg(RegResist, rand_coef(phase == 6 ? 1 : 0));
      write_reg(RegCompl, rand_coef(phase == 7 ? 2 : 0));
      if (phase == 2) -> hold_start;
      for (int n = 0; n < 225; n++) begin
        send_tick(rand_tick());
        if (n == 100) begin
          in_valid <= 1'b0;
          while (expected_scales.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Checked %0d words over directed cases and eight random phases,", checked);
    $display("covering slope and coefficient extremes, idle, stall and back-pressure.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
